[rtl/crt_pkg.sv]
// Shared constants, command codes and controller/datapath interface types.
`default_nettype none
package crt_pkg;

	// Field widths
	localparam int VAL_W = 32;
	localparam int NUM_W = 25;
	localparam int DEN_W = 10;
	localparam int PART_W = 2;

	// Default fraction bits of the input value
	localparam int FRAC_BITS_DEF = 16;

	// Register reset and limits
	localparam logic [DEN_W-1:0] MAXDEN_RST = 10'd1000;
	localparam logic [NUM_W-1:0] NUM_MAX = 25'h1FF_FFFF;

	// Result part codes
	localparam logic [PART_W-1:0] PART_DEG = 2'd0;
	localparam logic [PART_W-1:0] PART_MIN = 2'd1;
	localparam logic [PART_W-1:0] PART_SEC = 2'd2;

	// Datapath operations
	localparam int OP_W = 5;
	localparam logic [OP_W-1:0] OP_NONE   = 5'd0;
	localparam logic [OP_W-1:0] OP_LOAD   = 5'd1;
	localparam logic [OP_W-1:0] OP_START  = 5'd2;
	localparam logic [OP_W-1:0] OP_DIV_XY = 5'd3;
	localparam logic [OP_W-1:0] OP_MUL_QA = 5'd4;
	localparam logic [OP_W-1:0] OP_MUL_PA = 5'd5;
	localparam logic [OP_W-1:0] OP_STEP   = 5'd6;
	localparam logic [OP_W-1:0] OP_DIV_K1 = 5'd7;
	localparam logic [OP_W-1:0] OP_KSAV1  = 5'd8;
	localparam logic [OP_W-1:0] OP_DIV_K2 = 5'd9;
	localparam logic [OP_W-1:0] OP_KSAV2  = 5'd10;
	localparam logic [OP_W-1:0] OP_MUL_SP = 5'd11;
	localparam logic [OP_W-1:0] OP_MUL_SQ = 5'd12;
	localparam logic [OP_W-1:0] OP_E1A    = 5'd13;
	localparam logic [OP_W-1:0] OP_E1B    = 5'd14;
	localparam logic [OP_W-1:0] OP_E1C    = 5'd15;
	localparam logic [OP_W-1:0] OP_E2A    = 5'd16;
	localparam logic [OP_W-1:0] OP_E2B    = 5'd17;
	localparam logic [OP_W-1:0] OP_E2C    = 5'd18;
	localparam logic [OP_W-1:0] OP_PICK   = 5'd19;
	localparam logic [OP_W-1:0] OP_EMIT   = 5'd20;

	// Controller to datapath
	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [PART_W-1:0] part;
		logic              last;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic mode;
		logic div_busy;
		logic fit;
		logic rzero;
		logic p_zero;
		logic k_zero;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

[rtl/crt_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none
module crt_div (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [crt_pkg::VAL_W-1:0] dividend,
	input  wire logic [crt_pkg::VAL_W-1:0] divisor,
	output logic                           busy,
	output logic [crt_pkg::VAL_W-1:0]      quotient,
	output logic [crt_pkg::VAL_W-1:0]      remainder
);
	localparam int DW = crt_pkg::VAL_W;
	localparam int CW = $clog2(DW);

	logic [DW-1:0] quo_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] dvs_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [DW:0]   shifted;
	logic          take;

	// trial subtract of the shifted partial remainder
	assign shifted = {rem_q, quo_q[DW-1]};
	assign take = shifted >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= CW'(DW - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DW-2:0], take};
			rem_q <= take ? DW'(shifted - {1'b0, dvs_q}) : shifted[DW-1:0];
		end
	end

	assign busy = busy_q;
	assign quotient = quo_q;
	assign remainder = rem_q;

endmodule
`default_nettype wire

[rtl/crt_dp.sv]
// Datapath: operand registers, shared divider, products and result register.
`default_nettype none
module crt_dp #(
	parameter int FRAC_BITS = crt_pkg::FRAC_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_wr_en,
	input  wire logic [crt_pkg::DEN_W-1:0]   cfg_wr_data,
	input  wire logic                        mode,
	input  wire logic signed [crt_pkg::VAL_W-1:0] value,
	input  wire crt_pkg::cmd_t               cmd,
	output crt_pkg::sts_t                    sts,
	input  wire logic                        out_stall,
	output logic                             out_valid,
	output logic [crt_pkg::NUM_W-1:0]        numerator,
	output logic [crt_pkg::DEN_W-1:0]        denominator,
	output logic [crt_pkg::PART_W-1:0]       part,
	output logic                             last
);
	localparam int DW = crt_pkg::VAL_W;
	localparam int NW = crt_pkg::NUM_W;
	localparam int QW = crt_pkg::DEN_W;
	localparam int TW = FRAC_BITS + 6;
	localparam int NQW = QW + DW + 1;
	localparam int NPW = NW + DW + 1;
	localparam int MW = DW + QW;
	localparam int AW = NW + FRAC_BITS + 1;
	localparam int EW = AW + QW;
	localparam logic [DW-1:0] ONE = {{(DW-1){1'b0}}, 1'b1} << FRAC_BITS;
	localparam logic [TW-1:0] SIXTY = TW'(60);

	logic [QW-1:0]  maxden_q;
	logic [QW-1:0]  lim;
	logic           mode_q;
	logic [DW-1:0]  mag_q;
	logic [DW-1:0]  n_q;
	logic           d_one_q;
	logic [DW-1:0]  x_q, y_q;
	logic [NW-1:0]  p_q, pp_q, sp_q;
	logic [QW-1:0]  q_q, qp_q, sq_q, k_q;
	logic [NQW-1:0] nq_q;
	logic [NPW-1:0] np_q;
	logic [MW-1:0]  m_q;
	logic [AW-1:0]  t_q;
	logic [EW-1:0]  e1_q, e2_q;
	logic           out_valid_q;
	logic [NW-1:0]  out_num_q;
	logic [QW-1:0]  out_den_q;
	logic [crt_pkg::PART_W-1:0] out_part_q;
	logic           out_last_q;

	logic [DW-1:0]  mag_c;
	logic [TW-1:0]  t1, t2;
	logic [DW-1:0]  n_src;
	logic           d_one_src;
	logic           div_start, div_busy;
	logic [DW-1:0]  div_dvd, div_dvs, div_quo, div_rem;
	logic [MW-1:0]  qa;
	logic [NW+DW-1:0] pa;
	logic [NW+QW-1:0] pk;
	logic [2*QW-1:0]  qk;
	logic [MW-1:0]  nprod;
	logic [NW-1:0]  psel;
	logic [AW-1:0]  pd, m_ext, adiff;
	logic [EW-1:0]  eprod;
	logic           out_free;
	logic           fit;

	// configured bound, zero counts as one
	assign lim = (maxden_q == '0) ? QW'(1) : maxden_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			maxden_q <= crt_pkg::MAXDEN_RST;
		end else if (cfg_wr_en) begin
			maxden_q <= cfg_wr_data;
		end
	end

	// magnitude; the most negative value maps to 2^31
	assign mag_c = value[DW-1] ? DW'(~value + 1'b1) : DW'(value);

	// degrees / minutes / seconds split
	assign t1 = TW'(mag_q[FRAC_BITS-1:0]) * SIXTY;
	assign t2 = TW'(t1[FRAC_BITS-1:0]) * SIXTY;

	always_comb begin
		n_src = mag_q;
		d_one_src = 1'b0;
		if (mode_q) begin
			case (cmd.part)
				crt_pkg::PART_DEG: begin
					n_src = mag_q >> FRAC_BITS;
					d_one_src = 1'b1;
				end
				crt_pkg::PART_MIN: begin
					n_src = DW'(t1[TW-1:FRAC_BITS]);
					d_one_src = 1'b1;
				end
				default: begin
					n_src = DW'(t2);
					d_one_src = 1'b0;
				end
			endcase
		end
	end

	// divider operand select
	always_comb begin
		div_start = 1'b0;
		div_dvd = x_q;
		div_dvs = y_q;
		case (cmd.op)
			crt_pkg::OP_DIV_XY: begin
				div_start = 1'b1;
			end
			crt_pkg::OP_DIV_K1: begin
				div_start = 1'b1;
				div_dvd = DW'(lim - qp_q);
				div_dvs = DW'(q_q);
			end
			crt_pkg::OP_DIV_K2: begin
				div_start = 1'b1;
				div_dvd = DW'(crt_pkg::NUM_MAX - pp_q);
				div_dvs = DW'(p_q);
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	crt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.busy     (div_busy),
		.quotient (div_quo),
		.remainder(div_rem)
	);

	// products, one used per cycle
	assign qa = q_q * div_quo;
	assign pa = p_q * div_quo;
	assign pk = p_q * k_q;
	assign qk = q_q * k_q;
	assign nprod = n_q * ((cmd.op == crt_pkg::OP_E1A) ? q_q : sq_q);
	assign psel = (cmd.op == crt_pkg::OP_E1B) ? p_q : sp_q;
	assign pd = d_one_q ? AW'(psel) : (AW'(psel) << FRAC_BITS);
	assign m_ext = AW'(m_q);
	assign adiff = (m_ext > pd) ? (m_ext - pd) : (pd - m_ext);
	assign eprod = t_q * ((cmd.op == crt_pkg::OP_E1C) ? sq_q : q_q);

	assign fit = (nq_q <= NQW'(lim)) && (np_q <= NPW'(crt_pkg::NUM_MAX));
	assign out_free = !out_valid_q || !out_stall;

	// operand and expansion registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			crt_pkg::OP_LOAD: begin
				mode_q <= mode;
				mag_q <= mag_c;
			end
			crt_pkg::OP_START: begin
				n_q <= n_src;
				d_one_q <= d_one_src;
				x_q <= n_src;
				y_q <= d_one_src ? DW'(1) : ONE;
				p_q <= NW'(1);
				pp_q <= '0;
				q_q <= '0;
				qp_q <= QW'(1);
			end
			crt_pkg::OP_MUL_QA: begin
				nq_q <= NQW'(qa) + NQW'(qp_q);
			end
			crt_pkg::OP_MUL_PA: begin
				np_q <= NPW'(pa) + NPW'(pp_q);
			end
			crt_pkg::OP_STEP: begin
				if (fit) begin
					pp_q <= p_q;
					p_q <= np_q[NW-1:0];
					qp_q <= q_q;
					q_q <= nq_q[QW-1:0];
					x_q <= y_q;
					y_q <= div_rem;
				end
			end
			crt_pkg::OP_KSAV1: begin
				k_q <= div_quo[QW-1:0];
			end
			crt_pkg::OP_KSAV2: begin
				if (div_quo < DW'(k_q)) begin
					k_q <= div_quo[QW-1:0];
				end
			end
			crt_pkg::OP_MUL_SP: begin
				sp_q <= pk[NW-1:0] + pp_q;
			end
			crt_pkg::OP_MUL_SQ: begin
				sq_q <= qk[QW-1:0] + qp_q;
			end
			crt_pkg::OP_E1A, crt_pkg::OP_E2A: begin
				m_q <= nprod;
			end
			crt_pkg::OP_E1B, crt_pkg::OP_E2B: begin
				t_q <= adiff;
			end
			crt_pkg::OP_E1C: begin
				e1_q <= eprod;
			end
			crt_pkg::OP_E2C: begin
				e2_q <= eprod;
			end
			crt_pkg::OP_PICK: begin
				if (e2_q < e1_q) begin
					p_q <= sp_q;
					q_q <= sq_q;
				end
			end
			default: begin
			end
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == crt_pkg::OP_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == crt_pkg::OP_EMIT && out_free) begin
			out_num_q <= p_q;
			out_den_q <= q_q;
			out_part_q <= cmd.part;
			out_last_q <= cmd.last;
		end
	end

	assign out_valid = out_valid_q;
	assign numerator = out_num_q;
	assign denominator = out_den_q;
	assign part = out_part_q;
	assign last = out_last_q;

	// status to controller
	always_comb begin
		sts.mode = mode_q;
		sts.div_busy = div_busy;
		sts.fit = fit;
		sts.rzero = (div_rem == '0);
		sts.p_zero = (p_q == '0);
		sts.k_zero = (k_q == '0);
		sts.out_free = out_free;
	end

	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_den_q != '0))
		else $error("result with zero denominator");
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider restarted while busy");
	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == crt_pkg::OP_STEP && fit) |=> (q_q <= lim && q_q != '0))
		else $error("convergent denominator out of range");
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == crt_pkg::OP_EMIT) |-> out_free)
		else $error("result written over a pending request");

endmodule
`default_nettype wire

[rtl/crt_ctrl.sv]
// Controller: sequences the expansion, semiconvergent check and emission.
`default_nettype none
module crt_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_stall,
	input  wire crt_pkg::sts_t  sts,
	output crt_pkg::cmd_t       cmd
);
	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_START = 5'd1;
	localparam logic [4:0] S_DIVGO = 5'd2;
	localparam logic [4:0] S_DIVW  = 5'd3;
	localparam logic [4:0] S_MULQ  = 5'd4;
	localparam logic [4:0] S_MULP  = 5'd5;
	localparam logic [4:0] S_STEP  = 5'd6;
	localparam logic [4:0] S_K1GO  = 5'd7;
	localparam logic [4:0] S_K1W   = 5'd8;
	localparam logic [4:0] S_K1S   = 5'd9;
	localparam logic [4:0] S_K2GO  = 5'd10;
	localparam logic [4:0] S_K2W   = 5'd11;
	localparam logic [4:0] S_K2S   = 5'd12;
	localparam logic [4:0] S_KCHK  = 5'd13;
	localparam logic [4:0] S_SP    = 5'd14;
	localparam logic [4:0] S_SQ    = 5'd15;
	localparam logic [4:0] S_E1A   = 5'd16;
	localparam logic [4:0] S_E1B   = 5'd17;
	localparam logic [4:0] S_E1C   = 5'd18;
	localparam logic [4:0] S_E2A   = 5'd19;
	localparam logic [4:0] S_E2B   = 5'd20;
	localparam logic [4:0] S_E2C   = 5'd21;
	localparam logic [4:0] S_PICK  = 5'd22;
	localparam logic [4:0] S_EMIT  = 5'd23;

	logic [4:0] state_q, state_d;
	logic [crt_pkg::PART_W-1:0] part_q, part_d;
	logic is_last;

	assign is_last = !sts.mode || (part_q == crt_pkg::PART_SEC);
	assign in_stall = (state_q != S_IDLE);

	// next state and command
	always_comb begin
		state_d = state_q;
		part_d = part_q;
		cmd.op = crt_pkg::OP_NONE;
		cmd.part = part_q;
		cmd.last = is_last;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op = crt_pkg::OP_LOAD;
					part_d = crt_pkg::PART_DEG;
					state_d = S_START;
				end
			end
			S_START: begin
				cmd.op = crt_pkg::OP_START;
				state_d = S_DIVGO;
			end
			S_DIVGO: begin
				cmd.op = crt_pkg::OP_DIV_XY;
				state_d = S_DIVW;
			end
			S_DIVW: begin
				if (!sts.div_busy) state_d = S_MULQ;
			end
			S_MULQ: begin
				cmd.op = crt_pkg::OP_MUL_QA;
				state_d = S_MULP;
			end
			S_MULP: begin
				cmd.op = crt_pkg::OP_MUL_PA;
				state_d = S_STEP;
			end
			S_STEP: begin
				cmd.op = crt_pkg::OP_STEP;
				if (!sts.fit) state_d = S_K1GO;
				else if (sts.rzero) state_d = S_EMIT;
				else state_d = S_DIVGO;
			end
			S_K1GO: begin
				cmd.op = crt_pkg::OP_DIV_K1;
				state_d = S_K1W;
			end
			S_K1W: begin
				if (!sts.div_busy) state_d = S_K1S;
			end
			S_K1S: begin
				cmd.op = crt_pkg::OP_KSAV1;
				state_d = sts.p_zero ? S_KCHK : S_K2GO;
			end
			S_K2GO: begin
				cmd.op = crt_pkg::OP_DIV_K2;
				state_d = S_K2W;
			end
			S_K2W: begin
				if (!sts.div_busy) state_d = S_K2S;
			end
			S_K2S: begin
				cmd.op = crt_pkg::OP_KSAV2;
				state_d = S_KCHK;
			end
			S_KCHK: begin
				state_d = sts.k_zero ? S_EMIT : S_SP;
			end
			S_SP: begin
				cmd.op = crt_pkg::OP_MUL_SP;
				state_d = S_SQ;
			end
			S_SQ: begin
				cmd.op = crt_pkg::OP_MUL_SQ;
				state_d = S_E1A;
			end
			S_E1A: begin
				cmd.op = crt_pkg::OP_E1A;
				state_d = S_E1B;
			end
			S_E1B: begin
				cmd.op = crt_pkg::OP_E1B;
				state_d = S_E1C;
			end
			S_E1C: begin
				cmd.op = crt_pkg::OP_E1C;
				state_d = S_E2A;
			end
			S_E2A: begin
				cmd.op = crt_pkg::OP_E2A;
				state_d = S_E2B;
			end
			S_E2B: begin
				cmd.op = crt_pkg::OP_E2B;
				state_d = S_E2C;
			end
			S_E2C: begin
				cmd.op = crt_pkg::OP_E2C;
				state_d = S_PICK;
			end
			S_PICK: begin
				cmd.op = crt_pkg::OP_PICK;
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.op = crt_pkg::OP_EMIT;
					if (is_last) begin
						state_d = S_IDLE;
					end else begin
						part_d = part_q + 1'b1;
						state_d = S_START;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			part_q <= crt_pkg::PART_DEG;
		end else begin
			state_q <= state_d;
			part_q <= part_d;
		end
	end

endmodule
`default_nettype wire

[rtl/coordinate_to_rational_triple.sv]
// Top level: best rational approximation of a coordinate, single or triple.
//
//   channel  direction  handshake               payload
//   in       input      in_valid / in_stall     mode, value
//   out      output     out_valid / out_stall   numerator, denominator, part, last
//   cfg      input      cfg_wr_en               cfg_wr_data (max_denominator)
//
// Each rational takes a start step, then for each continued-fraction term a division, the
// two products and a step, then the semiconvergent check when the expansion is not exact,
// and an emit step; every division runs on the shared bit-serial divider.
// A single request gives one result, a triple request three, one after another.
// One request is worked at a time; the next is taken once the last result is registered.
// A stalled output holds its result and the controller waits before writing the next.
// Reset clears control state and sets max_denominator to 1000.
`default_nettype none
module coordinate_to_rational_triple #(
	parameter int FRAC_BITS = crt_pkg::FRAC_BITS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_wr_en,
	input  wire logic [crt_pkg::DEN_W-1:0]        cfg_wr_data,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic                             mode,
	input  wire logic signed [crt_pkg::VAL_W-1:0] value,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic [crt_pkg::NUM_W-1:0]             numerator,
	output logic [crt_pkg::DEN_W-1:0]             denominator,
	output logic [crt_pkg::PART_W-1:0]            part,
	output logic                                  last
);
	crt_pkg::cmd_t cmd;
	crt_pkg::sts_t sts;

	crt_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sts     (sts),
		.cmd     (cmd)
	);

	crt_dp #(
		.FRAC_BITS(FRAC_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.mode       (mode),
		.value      (value),
		.cmd        (cmd),
		.sts        (sts),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.numerator  (numerator),
		.denominator(denominator),
		.part       (part),
		.last       (last)
	);

endmodule
`default_nettype wire

[tb/tb_coordinate_to_rational_triple.sv]
// Testbench for coordinate_to_rational_triple: random and directed requests vs a predictor.
`timescale 1ns / 1ps
module tb_coordinate_to_rational_triple;

	localparam int FRAC = crt_pkg::FRAC_BITS_DEF;
	localparam int WATCHDOG_LIMIT = 40000;

	typedef struct {
		logic                      mode;
		logic [crt_pkg::VAL_W-1:0] value;
	} coord_t;

	typedef struct {
		logic [crt_pkg::NUM_W-1:0]  num;
		logic [crt_pkg::DEN_W-1:0]  den;
		logic [crt_pkg::PART_W-1:0] part;
		logic                       last;
	} frac_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [crt_pkg::DEN_W-1:0] cfg_wr_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic mode = 1'b0;
	logic signed [crt_pkg::VAL_W-1:0] value = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [crt_pkg::NUM_W-1:0] numerator;
	logic [crt_pkg::DEN_W-1:0] denominator;
	logic [crt_pkg::PART_W-1:0] part;
	logic last;

	coord_t pending_coords[$];
	frac_t expected_fracs[$];
	logic [crt_pkg::DEN_W-1:0] max_den = crt_pkg::MAXDEN_RST;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit drain_each = 1'b0;
	int mismatches = 0;
	int watchdog = 0;

	coordinate_to_rational_triple DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_stall(in_stall), .mode(mode), .value(value),
		.out_valid(out_valid), .out_stall(out_stall),
		.numerator(numerator), .denominator(denominator), .part(part), .last(last)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Best approximation of n/d under the denominator and numerator bounds
	function automatic frac_t best_rational(longint unsigned n, longint unsigned d,
			logic [crt_pkg::PART_W-1:0] pt, logic lst);
		longint unsigned lim, p, pp, q, qp, x, y, a, nq, np, r, k, kp, sp, sq, e1, e2;
		bit exact;
		frac_t f;
		lim = (max_den == 0) ? 1 : max_den;
		p = 1; pp = 0; q = 0; qp = 1; x = n; y = d; exact = 1'b0;
		while (1) begin
			a = x / y;
			nq = q * a + qp;
			np = p * a + pp;
			if (nq > lim || np > crt_pkg::NUM_MAX)
				break;
			pp = p; p = np;
			qp = q; q = nq;
			r = x - a * y;
			if (r == 0) begin
				exact = 1'b1;
				break;
			end
			x = y;
			y = r;
		end
		f.num = p[crt_pkg::NUM_W-1:0];
		f.den = q[crt_pkg::DEN_W-1:0];
		f.part = pt;
		f.last = lst;
		if (!exact) begin
			k = (lim - qp) / q;
			if (p != 0) begin
				kp = (crt_pkg::NUM_MAX - pp) / p;
				if (kp < k) k = kp;
			end
			if (k >= 1) begin
				sp = p * k + pp;
				sq = q * k + qp;
				e1 = ((n * q > p * d) ? n * q - p * d : p * d - n * q) * sq;
				e2 = ((n * sq > sp * d) ? n * sq - sp * d : sp * d - n * sq) * q;
				if (e2 < e1) begin
					f.num = sp[crt_pkg::NUM_W-1:0];
					f.den = sq[crt_pkg::DEN_W-1:0];
				end
			end
		end
		return f;
	endfunction

	// Expected results of one request
	task automatic predict_coord(coord_t c);
		longint unsigned mag, one, msk, t1, t2;
		one = 64'd1 << FRAC;
		msk = one - 1;
		mag = c.value[31] ? ((64'h1_0000_0000 - c.value) & 64'h1_FFFF_FFFF) : c.value;
		if (!c.mode) begin
			expected_fracs.push_back(best_rational(mag, one, crt_pkg::PART_DEG, 1'b1));
		end else begin
			t1 = (mag & msk) * 60;
			t2 = (t1 & msk) * 60;
			expected_fracs.push_back(best_rational(mag >> FRAC, 1, crt_pkg::PART_DEG, 1'b0));
			expected_fracs.push_back(best_rational(t1 >> FRAC, 1, crt_pkg::PART_MIN, 1'b0));
			expected_fracs.push_back(best_rational(t2, one, crt_pkg::PART_SEC, 1'b1));
		end
	endtask

	// Request driver
	always @(posedge clk) begin
		if (arst_n && (!in_valid || !in_stall)) begin
			if (in_valid)
				predict_coord('{mode: mode, value: value});
			if (pending_coords.size() != 0 && $urandom_range(99) >= send_idle_pct
					&& (!drain_each || (expected_fracs.size() == 0 && !in_valid))) begin
				in_valid <= 1'b1;
				mode <= pending_coords[0].mode;
				value <= pending_coords[0].value;
				void'(pending_coords.pop_front());
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Result monitor
	always @(posedge clk) begin
		frac_t e;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_fracs.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result num=%0d den=%0d part=%0d last=%0d",
							numerator, denominator, part, last);
				end else begin
					e = expected_fracs.pop_front();
					if (e.num !== numerator || e.den !== denominator || e.part !== part
							|| e.last !== last) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"mismatch: exp %0d/%0d part %0d last %0d, ",
								"got %0d/%0d part %0d last %0d"},
								e.num, e.den, e.part, e.last,
								numerator, denominator, part, last);
					end
				end
			end
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Watchdog on cycles without any accepted transfer
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			watchdog <= 0;
		else
			watchdog <= watchdog + 1;
		if (watchdog >= WATCHDOG_LIMIT) begin
			$display("coordinate_to_rational_triple verification failed");
			$finish;
		end
	end

	task automatic wait_idle();
		while (pending_coords.size() != 0 || in_valid || expected_fracs.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_max_den(logic [crt_pkg::DEN_W-1:0] v);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		max_den = v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic queue_coord(logic m, logic [crt_pkg::VAL_W-1:0] v);
		pending_coords.push_back('{mode: m, value: v});
	endtask

	// Random requests: full range, small magnitudes, short fractions
	task automatic queue_random(int count);
		logic [crt_pkg::VAL_W-1:0] v;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(3))
				0: v = $urandom_range(200 << FRAC);
				1: v = $urandom & 32'hFFFF_FF00;
				2: v = -$urandom_range(1 << FRAC);
				default: v = $urandom;
			endcase
			queue_coord(1'($urandom_range(1)), v);
		end
	endtask

	initial begin
		logic [crt_pkg::DEN_W-1:0] dens[6];
		dens = '{10'd1000, 10'd1023, 10'd1, 10'd0, 10'd7, 10'd0};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes, exact values, integer and triple cases
		for (int m = 0; m < 2; m++) begin
			queue_coord(1'(m), 32'h0000_0000);
			queue_coord(1'(m), 32'h0000_0001);
			queue_coord(1'(m), 32'hFFFF_FFFF);
			queue_coord(1'(m), 32'h7FFF_FFFF);
			queue_coord(1'(m), 32'h8000_0000);
			queue_coord(1'(m), 32'h0002_0000);
			queue_coord(1'(m), 32'h0003_243F);
			queue_coord(1'(m), 32'h00B4_0000);
			queue_coord(1'(m), 32'hFFA5_8000);
			queue_coord(1'(m), 32'h0000_FFFF);
			queue_coord(1'(m), 32'h5555_5555);
		end
		wait_idle();

		// Phases over register settings and idling patterns
		for (int ph = 0; ph < 6; ph++) begin
			dens[5] = 10'($urandom_range(1023));
			if (ph != 0)
				write_max_den(dens[ph]);
			case (ph % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 53; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 53; end
				default: begin send_idle_pct = 32; recv_stall_pct = 32; end
			endcase
			drain_each = (ph == 2);
			queue_random(80);
			wait_idle();
			drain_each = 1'b0;
		end
		write_max_den(10'd1023);
		queue_coord(1'b0, 32'h7FFF_FFFF);
		queue_coord(1'b0, 32'h8000_0000);
		wait_idle();

		repeat (200) @(posedge clk);
		if (mismatches == 0 && expected_fracs.size() == 0)
			$display("coordinate_to_rational_triple verification clean");
		else
			$display("coordinate_to_rational_triple verification failed");
		$finish;
	end
endmodule
